### rtl/core/cmds_pkg.sv
// Shared types and constants of the CAN motor drive supervisor.
// Used by every module under rtl/core; depends on nothing else.

package cmds_pkg;

    // Field widths of the item and result ports.
    localparam int NODE_W  = 6;
    localparam int CMD_W   = 5;
    localparam int ID_W    = 11;
    localparam int LEN_W   = 4;
    localparam int WORD_W  = 32;
    localparam int STATE_W = 8;
    localparam int PERIOD_W = 16;
    localparam int CFG_INDEX_W = 3;

    // Operation codes of an input item.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Drive command codes, the low five identifier bits.
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT  = 5'h01;
    localparam logic [CMD_W-1:0] CMD_AXIS_STATE = 5'h07;
    localparam logic [CMD_W-1:0] CMD_ENCODER    = 5'h09;
    localparam logic [CMD_W-1:0] CMD_CTRL_MODE  = 5'h0B;
    localparam logic [CMD_W-1:0] CMD_INPUT_VEL  = 5'h0D;
    localparam logic [CMD_W-1:0] CMD_IQ         = 5'h14;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ERR  = 5'h18;

    // Payload constants of the enable sequence.
    localparam logic [STATE_W-1:0] STATE_CLOSED_LOOP = 8'd8;
    localparam logic [WORD_W-1:0]  MODE_VELOCITY     = 32'd2;
    localparam logic [WORD_W-1:0]  INPUT_PASSTHROUGH = 32'd1;

    // Payload lengths.
    localparam logic [LEN_W-1:0] LEN_NONE      = 4'd0;
    localparam logic [LEN_W-1:0] LEN_ONE       = 4'd1;
    localparam logic [LEN_W-1:0] LEN_FOUR      = 4'd4;
    localparam logic [LEN_W-1:0] LEN_HEARTBEAT = 4'd6;
    localparam logic [LEN_W-1:0] LEN_FULL      = 4'd8;

    // Beat indexes of the three-frame enable sequence.
    localparam logic [1:0] BEAT_CLEAR = 2'd0;
    localparam logic [1:0] BEAT_MODE  = 2'd1;
    localparam logic [1:0] BEAT_STATE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_RETRY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HB_TIMEOUT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_VEL    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_ENABLED = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_FF     = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [NODE_W-1:0]   RST_NODE_ADDRESS   = 6'd0;
    localparam logic [PERIOD_W-1:0] RST_COMMAND_PERIOD = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_ENABLE_RETRY   = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_HB_TIMEOUT     = 16'd500;
    localparam logic [WORD_W-1:0]   RST_TARGET_VEL     = 32'h3F80_0000;
    localparam logic                RST_DRIVE_ENABLED  = 1'b1;
    localparam logic [WORD_W-1:0]   RST_TORQUE_FF      = 32'h0000_0000;

    // What one processed item asks the result sequencer to send.
    typedef enum logic [1:0] {
        BURST_NONE,
        BURST_ENABLE,
        BURST_VELOCITY
    } burst_kind_t;

    // Current configuration, as seen by the datapath.
    typedef struct packed {
        logic [NODE_W-1:0]   node_address;
        logic [PERIOD_W-1:0] command_period_ms;
        logic [PERIOD_W-1:0] enable_retry_ms;
        logic [PERIOD_W-1:0] heartbeat_timeout_ms;
        logic [WORD_W-1:0]   target_velocity_bits;
        logic                drive_enabled;
        logic [WORD_W-1:0]   torque_feedforward_bits;
    } cfg_t;

    // Decision and status snapshot handed from the core to the sequencer.
    typedef struct packed {
        burst_kind_t         kind;
        logic                fresh;
        logic [STATE_W-1:0]  drive_state;
        logic [WORD_W-1:0]   drive_error;
        logic [WORD_W-1:0]   position_bits;
        logic [WORD_W-1:0]   speed_bits;
        logic [WORD_W-1:0]   current_bits;
    } burst_t;

endpackage

### rtl/core/can_motor_drive_supervisor_unit.sv
// Top level of the CAN motor drive supervisor.
// Depends on cmds_pkg, cmds_config, cmds_core and cmds_out.

// The block takes one item per cycle while in_ready is high: a received
// frame or a time tick, each with the current millisecond time. An item
// waits in the input register and moves into the result register when the
// result sequencer can take it; its first result is then on the outputs. A
// frame, or a tick that sends nothing or one velocity frame, gives one result
// and lets a new item in every cycle while out_ready is high; a tick that
// starts the enable sequence gives three results, and the result sequencer
// holds the next item until the last of them is taken. Status fields in every
// result show the stored drive values after the item.
// Configuration writes take effect at once and are meant for idle periods.

module can_motor_drive_supervisor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cmds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmds_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [cmds_pkg::WORD_W-1:0]      now_ms,
    input  logic [cmds_pkg::ID_W-1:0]        rx_id,
    input  logic [cmds_pkg::LEN_W-1:0]       rx_length,
    input  logic [cmds_pkg::WORD_W-1:0]      rx_low_word,
    input  logic [cmds_pkg::WORD_W-1:0]      rx_high_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             send_valid,
    output logic [cmds_pkg::ID_W-1:0]        tx_id,
    output logic [cmds_pkg::LEN_W-1:0]       tx_length,
    output logic [cmds_pkg::WORD_W-1:0]      tx_low_word,
    output logic [cmds_pkg::WORD_W-1:0]      tx_high_word,
    output logic                             last,
    output logic                             heartbeat_fresh,
    output logic [cmds_pkg::STATE_W-1:0]     drive_state,
    output logic [cmds_pkg::WORD_W-1:0]      drive_error,
    output logic [cmds_pkg::WORD_W-1:0]      position_bits,
    output logic [cmds_pkg::WORD_W-1:0]      speed_bits,
    output logic [cmds_pkg::WORD_W-1:0]      current_bits
);
    import cmds_pkg::*;

    cfg_t   cfg;
    burst_t burst;
    logic   burst_valid;
    logic   burst_ready;

    // Configuration registers.
    cmds_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, status store and send decision.
    cmds_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now_ms       (now_ms),
        .rx_id        (rx_id),
        .rx_length    (rx_length),
        .rx_low_word  (rx_low_word),
        .rx_high_word (rx_high_word),
        .burst_valid  (burst_valid),
        .burst_ready  (burst_ready),
        .burst        (burst)
    );

    // Result register and frame sequencer.
    cmds_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .burst_valid     (burst_valid),
        .burst_ready     (burst_ready),
        .burst           (burst),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .send_valid      (send_valid),
        .tx_id           (tx_id),
        .tx_length       (tx_length),
        .tx_low_word     (tx_low_word),
        .tx_high_word    (tx_high_word),
        .last            (last),
        .heartbeat_fresh (heartbeat_fresh),
        .drive_state     (drive_state),
        .drive_error     (drive_error),
        .position_bits   (position_bits),
        .speed_bits      (speed_bits),
        .current_bits    (current_bits)
    );

endmodule

### rtl/core/cmds_config.sv
// Configuration register file of the CAN motor drive supervisor.
// Depends on cmds_pkg for the register indexes, reset values and cfg_t.

module cmds_config (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cmds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmds_pkg::WORD_W-1:0]      cfg_data,
    output cmds_pkg::cfg_t                   cfg
);
    import cmds_pkg::*;

    cfg_t cfg_reg;

    // Write one register per enabled cycle; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_address            <= RST_NODE_ADDRESS;
            cfg_reg.command_period_ms       <= RST_COMMAND_PERIOD;
            cfg_reg.enable_retry_ms         <= RST_ENABLE_RETRY;
            cfg_reg.heartbeat_timeout_ms    <= RST_HB_TIMEOUT;
            cfg_reg.target_velocity_bits    <= RST_TARGET_VEL;
            cfg_reg.drive_enabled           <= RST_DRIVE_ENABLED;
            cfg_reg.torque_feedforward_bits <= RST_TORQUE_FF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NODE_ADDRESS:   cfg_reg.node_address <= cfg_data[NODE_W-1:0];
                REG_COMMAND_PERIOD: cfg_reg.command_period_ms <= cfg_data[PERIOD_W-1:0];
                REG_ENABLE_RETRY:   cfg_reg.enable_retry_ms <= cfg_data[PERIOD_W-1:0];
                REG_HB_TIMEOUT:     cfg_reg.heartbeat_timeout_ms <= cfg_data[PERIOD_W-1:0];
                REG_TARGET_VEL:     cfg_reg.target_velocity_bits <= cfg_data;
                REG_DRIVE_ENABLED:  cfg_reg.drive_enabled <= cfg_data[0];
                REG_TORQUE_FF:      cfg_reg.torque_feedforward_bits <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/cmds_core.sv
// Input register, drive status store and send decision of the supervisor.
// Depends on cmds_pkg for codes, cfg_t and burst_t.

module cmds_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmds_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [cmds_pkg::WORD_W-1:0]   now_ms,
    input  logic [cmds_pkg::ID_W-1:0]     rx_id,
    input  logic [cmds_pkg::LEN_W-1:0]    rx_length,
    input  logic [cmds_pkg::WORD_W-1:0]   rx_low_word,
    input  logic [cmds_pkg::WORD_W-1:0]   rx_high_word,
    output logic                          burst_valid,
    input  logic                          burst_ready,
    output cmds_pkg::burst_t              burst
);
    import cmds_pkg::*;

    // Input register.
    logic               ivld_reg;
    logic               op_reg;
    logic [WORD_W-1:0]  now_reg;
    logic [ID_W-1:0]    id_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [WORD_W-1:0]  low_reg;
    logic [WORD_W-1:0]  high_reg;

    // Drive status and time stamps.
    logic [WORD_W-1:0]  hb_stamp_reg,  hb_stamp_next;
    logic [WORD_W-1:0]  en_stamp_reg,  en_stamp_next;
    logic [WORD_W-1:0]  cmd_stamp_reg, cmd_stamp_next;
    logic [WORD_W-1:0]  error_reg,     error_next;
    logic [STATE_W-1:0] state_reg,     state_next;
    logic [WORD_W-1:0]  pos_reg,       pos_next;
    logic [WORD_W-1:0]  speed_reg,     speed_next;
    logic [WORD_W-1:0]  current_reg,   current_next;

    logic               take;
    logic               node_hit;
    logic [CMD_W-1:0]   rx_cmd;
    logic [WORD_W-1:0]  hb_age;
    logic [WORD_W-1:0]  en_age;
    logic [WORD_W-1:0]  cmd_age;
    logic               fresh;
    logic               enable_due;
    logic               velocity_due;
    burst_kind_t        kind;

    assign take        = ivld_reg && burst_ready;
    assign in_ready    = !ivld_reg || burst_ready;
    assign burst_valid = ivld_reg;

    // Hold an item until the sequencer takes its decision.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            now_reg  <= now_ms;
            id_reg   <= rx_id;
            len_reg  <= rx_length;
            low_reg  <= rx_low_word;
            high_reg <= rx_high_word;
        end
    end

    assign node_hit = (id_reg[ID_W-1:CMD_W] == cfg.node_address);
    assign rx_cmd   = id_reg[CMD_W-1:0];

    // A frame for this node updates the status; lengths above eight count as eight.
    always_comb
    begin
        hb_stamp_next = hb_stamp_reg;
        error_next    = error_reg;
        state_next    = state_reg;
        pos_next      = pos_reg;
        speed_next    = speed_reg;
        current_next  = current_reg;
        if (op_reg == OP_FRAME && node_hit)
        begin
            case (rx_cmd)
                CMD_HEARTBEAT:
                begin
                    if (len_reg >= LEN_HEARTBEAT)
                    begin
                        error_next    = low_reg;
                        state_next    = high_reg[STATE_W-1:0];
                        hb_stamp_next = now_reg;
                    end
                end
                CMD_ENCODER:
                begin
                    if (len_reg >= LEN_FULL)
                    begin
                        pos_next   = low_reg;
                        speed_next = high_reg;
                    end
                end
                CMD_IQ:
                begin
                    if (len_reg >= LEN_FULL)
                    begin
                        current_next = high_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Freshness uses the stamp after this item; a stamp of zero means never heard.
    assign hb_age  = now_reg - hb_stamp_next;
    assign fresh   = (hb_stamp_next != '0) &&
                     (hb_age <= {{(WORD_W-PERIOD_W){1'b0}}, cfg.heartbeat_timeout_ms});
    assign en_age  = now_reg - en_stamp_reg;
    assign cmd_age = now_reg - cmd_stamp_reg;

    assign enable_due   = (state_reg != STATE_CLOSED_LOOP) &&
                          (en_age >= {{(WORD_W-PERIOD_W){1'b0}}, cfg.enable_retry_ms});
    assign velocity_due = (state_reg == STATE_CLOSED_LOOP) &&
                          (cmd_age >= {{(WORD_W-PERIOD_W){1'b0}}, cfg.command_period_ms});

    // A tick with a fresh, error-free heartbeat may start a send.
    always_comb
    begin
        kind           = BURST_NONE;
        en_stamp_next  = en_stamp_reg;
        cmd_stamp_next = cmd_stamp_reg;
        if (op_reg == OP_TICK && fresh && error_reg == '0)
        begin
            if (enable_due)
            begin
                kind          = BURST_ENABLE;
                en_stamp_next = now_reg;
            end
            else if (velocity_due)
            begin
                kind           = BURST_VELOCITY;
                cmd_stamp_next = now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_stamp_reg  <= '0;
            en_stamp_reg  <= '0;
            cmd_stamp_reg <= '0;
            error_reg     <= '0;
            state_reg     <= '0;
            pos_reg       <= '0;
            speed_reg     <= '0;
            current_reg   <= '0;
        end
        else if (take)
        begin
            hb_stamp_reg  <= hb_stamp_next;
            en_stamp_reg  <= en_stamp_next;
            cmd_stamp_reg <= cmd_stamp_next;
            error_reg     <= error_next;
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            speed_reg     <= speed_next;
            current_reg   <= current_next;
        end
    end

    assign burst.kind          = kind;
    assign burst.fresh         = fresh;
    assign burst.drive_state   = state_next;
    assign burst.drive_error   = error_next;
    assign burst.position_bits = pos_next;
    assign burst.speed_bits    = speed_next;
    assign burst.current_bits  = current_next;

    // A held item stays until the sequencer takes it.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        ivld_reg && !burst_ready |=> ivld_reg)
        else $error("item dropped while the sequencer was busy");

    // Only a tick can start a send.
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        ivld_reg && op_reg == OP_FRAME |-> kind == BURST_NONE)
        else $error("a received frame started a send");

    // The enable stamp of a taken enable sequence is the item's time.
    a_stamp_now: assert property (@(posedge clk) disable iff (!rst_n)
        take && kind == BURST_ENABLE |=> en_stamp_reg == $past(now_reg))
        else $error("enable stamp not taken from the item");

endmodule

### rtl/core/cmds_out.sv
// Result sequencer: result register that emits one or three results per item.
// Depends on cmds_pkg for command codes, cfg_t and burst_t.

module cmds_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmds_pkg::cfg_t                cfg,
    input  logic                          burst_valid,
    output logic                          burst_ready,
    input  cmds_pkg::burst_t              burst,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          send_valid,
    output logic [cmds_pkg::ID_W-1:0]     tx_id,
    output logic [cmds_pkg::LEN_W-1:0]    tx_length,
    output logic [cmds_pkg::WORD_W-1:0]   tx_low_word,
    output logic [cmds_pkg::WORD_W-1:0]   tx_high_word,
    output logic                          last,
    output logic                          heartbeat_fresh,
    output logic [cmds_pkg::STATE_W-1:0]  drive_state,
    output logic [cmds_pkg::WORD_W-1:0]   drive_error,
    output logic [cmds_pkg::WORD_W-1:0]   position_bits,
    output logic [cmds_pkg::WORD_W-1:0]   speed_bits,
    output logic [cmds_pkg::WORD_W-1:0]   current_bits
);
    import cmds_pkg::*;

    logic       ovld_reg;
    logic [1:0] beat_reg;
    burst_t     burst_reg;
    logic [CMD_W-1:0] tx_cmd;
    logic       load;

    // A new burst loads when the register is empty or its last result leaves.
    assign burst_ready = !ovld_reg || (out_ready && last);
    assign load        = burst_valid && burst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
            beat_reg <= BEAT_CLEAR;
        end
        else if (load)
        begin
            ovld_reg <= 1'b1;
            beat_reg <= BEAT_CLEAR;
        end
        else if (ovld_reg && out_ready)
        begin
            if (last)
            begin
                ovld_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    // Frame contents for the current beat.
    always_comb
    begin
        send_valid   = 1'b0;
        tx_cmd       = '0;
        tx_length    = LEN_NONE;
        tx_low_word  = '0;
        tx_high_word = '0;
        last         = 1'b1;
        case (burst_reg.kind)
            BURST_ENABLE:
            begin
                send_valid = 1'b1;
                last       = (beat_reg == BEAT_STATE);
                case (beat_reg)
                    BEAT_CLEAR:
                    begin
                        tx_cmd    = CMD_CLEAR_ERR;
                        tx_length = LEN_ONE;
                    end
                    BEAT_MODE:
                    begin
                        tx_cmd       = CMD_CTRL_MODE;
                        tx_length    = LEN_FULL;
                        tx_low_word  = MODE_VELOCITY;
                        tx_high_word = INPUT_PASSTHROUGH;
                    end
                    default:
                    begin
                        tx_cmd      = CMD_AXIS_STATE;
                        tx_length   = LEN_FOUR;
                        tx_low_word = {{(WORD_W-STATE_W){1'b0}}, STATE_CLOSED_LOOP};
                    end
                endcase
            end
            BURST_VELOCITY:
            begin
                send_valid   = 1'b1;
                tx_cmd       = CMD_INPUT_VEL;
                tx_length    = LEN_FULL;
                tx_low_word  = cfg.drive_enabled ? cfg.target_velocity_bits : '0;
                tx_high_word = cfg.torque_feedforward_bits;
            end
            default: ;
        endcase
    end

    assign tx_id           = send_valid ? {cfg.node_address, tx_cmd} : '0;
    assign out_valid       = ovld_reg;
    assign heartbeat_fresh = burst_reg.fresh;
    assign drive_state     = burst_reg.drive_state;
    assign drive_error     = burst_reg.drive_error;
    assign position_bits   = burst_reg.position_bits;
    assign speed_bits      = burst_reg.speed_bits;
    assign current_bits    = burst_reg.current_bits;

    // Only an enable sequence moves past the first beat.
    a_beat_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && burst_reg.kind != BURST_ENABLE |-> beat_reg == BEAT_CLEAR)
        else $error("beat advanced on a single-result item");

    // The beat never runs past the last frame of a sequence.
    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && beat_reg == BEAT_STATE |-> last)
        else $error("beat ran past the enable sequence");

    // A taken result that is not last advances the beat.
    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && out_ready && !last |=> ovld_reg && beat_reg == $past(beat_reg) + 2'd1)
        else $error("enable sequence lost a frame");

endmodule

### tb/supervisor_checker.sv
`timescale 1ns / 1ps
// Result checker for the CAN motor drive supervisor: follows register writes,
// predicts the result items of every accepted input item and compares them in order.
// Depends on cmds_pkg.

module supervisor_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cmds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmds_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             operation,
    input  logic [cmds_pkg::WORD_W-1:0]      now_ms,
    input  logic [cmds_pkg::ID_W-1:0]        rx_id,
    input  logic [cmds_pkg::LEN_W-1:0]       rx_length,
    input  logic [cmds_pkg::WORD_W-1:0]      rx_low_word,
    input  logic [cmds_pkg::WORD_W-1:0]      rx_high_word,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             send_valid,
    input  logic [cmds_pkg::ID_W-1:0]        tx_id,
    input  logic [cmds_pkg::LEN_W-1:0]       tx_length,
    input  logic [cmds_pkg::WORD_W-1:0]      tx_low_word,
    input  logic [cmds_pkg::WORD_W-1:0]      tx_high_word,
    input  logic                             last,
    input  logic                             heartbeat_fresh,
    input  logic [cmds_pkg::STATE_W-1:0]     drive_state,
    input  logic [cmds_pkg::WORD_W-1:0]      drive_error,
    input  logic [cmds_pkg::WORD_W-1:0]      position_bits,
    input  logic [cmds_pkg::WORD_W-1:0]      speed_bits,
    input  logic [cmds_pkg::WORD_W-1:0]      current_bits,
    output int                               mismatches,
    output int                               outstanding
);
    import cmds_pkg::*;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic               send;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [WORD_W-1:0]  lo;
        logic [WORD_W-1:0]  hi;
        logic               fin;
        logic               fresh;
        logic [STATE_W-1:0] state;
        logic [WORD_W-1:0]  err_word;
        logic [WORD_W-1:0]  position;
        logic [WORD_W-1:0]  speed;
        logic [WORD_W-1:0]  current;
    } frame_result_t;

    // Register copies.
    logic [NODE_W-1:0]   node_cfg;
    logic [PERIOD_W-1:0] period_cfg;
    logic [PERIOD_W-1:0] retry_cfg;
    logic [PERIOD_W-1:0] timeout_cfg;
    logic [WORD_W-1:0]   velocity_cfg;
    logic                enabled_cfg;
    logic [WORD_W-1:0]   torque_cfg;

    // Drive state as the block should hold it.
    logic [WORD_W-1:0]   hb_stamp;
    logic [WORD_W-1:0]   enable_stamp;
    logic [WORD_W-1:0]   command_stamp;
    logic [WORD_W-1:0]   error_word;
    logic [STATE_W-1:0]  state_code;
    logic [WORD_W-1:0]   position_word;
    logic [WORD_W-1:0]   speed_word;
    logic [WORD_W-1:0]   current_word;

    frame_result_t expected_frames[$];

    // A heartbeat stamped at zero counts as never heard.
    function automatic logic heartbeat_recent(input logic [WORD_W-1:0] now);
        logic [WORD_W-1:0] age;
        age = now - hb_stamp;
        return (hb_stamp != '0) && (age <= timeout_cfg);
    endfunction

    function automatic void queue_frame(input logic send, input logic [CMD_W-1:0] cmd,
                                        input logic [LEN_W-1:0] len,
                                        input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi,
                                        input logic fin, input logic fresh);
        frame_result_t r;
        r.send     = send;
        r.id       = send ? {node_cfg, cmd} : '0;
        r.len      = len;
        r.lo       = lo;
        r.hi       = hi;
        r.fin      = fin;
        r.fresh    = fresh;
        r.state    = state_code;
        r.err_word = error_word;
        r.position = position_word;
        r.speed    = speed_word;
        r.current  = current_word;
        expected_frames.push_back(r);
    endfunction

    // Updates the drive state for one item and queues the frames it causes.
    function automatic void predict_frames(input logic op, input logic [WORD_W-1:0] now,
                                           input logic [ID_W-1:0] id,
                                           input logic [LEN_W-1:0] len_in,
                                           input logic [WORD_W-1:0] lo,
                                           input logic [WORD_W-1:0] hi);
        logic [LEN_W-1:0]  len;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] since_enable;
        logic [WORD_W-1:0] since_command;
        logic              fresh;
        len = (len_in > LEN_FULL) ? LEN_FULL : len_in;
        cmd = id[CMD_W-1:0];
        if (op == OP_FRAME)
        begin
            if (id[ID_W-1:CMD_W] == node_cfg)
            begin
                if (cmd == CMD_HEARTBEAT && len >= LEN_HEARTBEAT)
                begin
                    error_word = lo;
                    state_code = hi[STATE_W-1:0];
                    hb_stamp   = now;
                end
                else if (cmd == CMD_ENCODER && len == LEN_FULL)
                begin
                    position_word = lo;
                    speed_word    = hi;
                end
                else if (cmd == CMD_IQ && len == LEN_FULL)
                begin
                    current_word = hi;
                end
            end
            queue_frame(1'b0, '0, LEN_NONE, '0, '0, 1'b1, heartbeat_recent(now));
            return;
        end
        fresh         = heartbeat_recent(now);
        since_enable  = now - enable_stamp;
        since_command = now - command_stamp;
        if (fresh && error_word == '0)
        begin
            // Axis not yet in closed loop: the three-frame enable sequence.
            if (state_code != STATE_CLOSED_LOOP && since_enable >= retry_cfg)
            begin
                enable_stamp = now;
                queue_frame(1'b1, CMD_CLEAR_ERR, LEN_ONE, '0, '0, 1'b0, 1'b1);
                queue_frame(1'b1, CMD_CTRL_MODE, LEN_FULL, MODE_VELOCITY,
                            INPUT_PASSTHROUGH, 1'b0, 1'b1);
                queue_frame(1'b1, CMD_AXIS_STATE, LEN_FOUR, {24'd0, STATE_CLOSED_LOOP},
                            '0, 1'b1, 1'b1);
                return;
            end
            // Closed loop: one velocity command per period.
            if (state_code == STATE_CLOSED_LOOP && since_command >= period_cfg)
            begin
                command_stamp = now;
                queue_frame(1'b1, CMD_INPUT_VEL, LEN_FULL,
                            enabled_cfg ? velocity_cfg : '0, torque_cfg, 1'b1, 1'b1);
                return;
            end
        end
        queue_frame(1'b0, '0, LEN_NONE, '0, '0, 1'b1, fresh);
    endfunction

    function automatic string show(input frame_result_t r);
        return $sformatf("send=%0b id=%h len=%0d lo=%h hi=%h last=%0b fresh=%0b st=%h %s",
                         r.send, r.id, r.len, r.lo, r.hi, r.fin, r.fresh, r.state,
                         $sformatf("err=%h pos=%h spd=%h cur=%h",
                                   r.err_word, r.position, r.speed, r.current));
    endfunction

    // Sample all channels at the rising edge; compare before predicting.
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t seen;
        frame_result_t want;
        if (!rst_n)
        begin
            node_cfg      = RST_NODE_ADDRESS;
            period_cfg    = RST_COMMAND_PERIOD;
            retry_cfg     = RST_ENABLE_RETRY;
            timeout_cfg   = RST_HB_TIMEOUT;
            velocity_cfg  = RST_TARGET_VEL;
            enabled_cfg   = RST_DRIVE_ENABLED;
            torque_cfg    = RST_TORQUE_FF;
            hb_stamp      = '0;
            enable_stamp  = '0;
            command_stamp = '0;
            error_word    = '0;
            state_code    = '0;
            position_word = '0;
            speed_word    = '0;
            current_word  = '0;
            expected_frames.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_NODE_ADDRESS:   node_cfg     = cfg_data[NODE_W-1:0];
                    REG_COMMAND_PERIOD: period_cfg   = cfg_data[PERIOD_W-1:0];
                    REG_ENABLE_RETRY:   retry_cfg    = cfg_data[PERIOD_W-1:0];
                    REG_HB_TIMEOUT:     timeout_cfg  = cfg_data[PERIOD_W-1:0];
                    REG_TARGET_VEL:     velocity_cfg = cfg_data;
                    REG_DRIVE_ENABLED:  enabled_cfg  = cfg_data[0];
                    REG_TORQUE_FF:      torque_cfg   = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                seen = {send_valid, tx_id, tx_length, tx_low_word, tx_high_word, last,
                        heartbeat_fresh, drive_state, drive_error, position_bits,
                        speed_bits, current_bits};
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: %s", $realtime,
                                 show(seen));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(seen));
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                predict_frames(operation, now_ms, rx_id, rx_length, rx_low_word,
                               rx_high_word);
            outstanding = expected_frames.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the supervisor testbench: clock, reset, register writes, item stimulus
// and the verdict. Depends on cmds_pkg, can_motor_drive_supervisor_unit and supervisor_checker.

module testbench;
    import cmds_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 40;
    // Command code the drive never uses.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 5'h1F;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   operation;
    logic [WORD_W-1:0]      now_ms;
    logic [ID_W-1:0]        rx_id;
    logic [LEN_W-1:0]       rx_length;
    logic [WORD_W-1:0]      rx_low_word;
    logic [WORD_W-1:0]      rx_high_word;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   send_valid;
    logic [ID_W-1:0]        tx_id;
    logic [LEN_W-1:0]       tx_length;
    logic [WORD_W-1:0]      tx_low_word;
    logic [WORD_W-1:0]      tx_high_word;
    logic                   last;
    logic                   heartbeat_fresh;
    logic [STATE_W-1:0]     drive_state;
    logic [WORD_W-1:0]      drive_error;
    logic [WORD_W-1:0]      position_bits;
    logic [WORD_W-1:0]      speed_bits;
    logic [WORD_W-1:0]      current_bits;
    int                     mismatches;
    int                     outstanding;

    int                     sender_idle_pct = 0;
    int                     stall_pct = 0;
    int                     hold_requests = 0;
    int                     hold_served = 0;
    int                     hold_left = 0;
    int                     cycle_count = 0;
    logic [WORD_W-1:0]      clock_ms;
    logic [NODE_W-1:0]      node_now;

    can_motor_drive_supervisor_unit i_dut (.*);

    supervisor_checker i_checker (.*);

    always #10 clk = ~clk;

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one item, with random idle cycles first, and waits until it is taken.
    task automatic offer_item(input logic op, input logic [WORD_W-1:0] now,
                              input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        now_ms       <= now;
        rx_id        <= id;
        rx_length    <= len;
        rx_low_word  <= lo;
        rx_high_word <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Ticks carry random contents in the frame fields, which must not matter.
    task automatic tick_item(input logic [WORD_W-1:0] now);
        offer_item(OP_TICK, now, ID_W'($urandom), LEN_W'($urandom), $urandom, $urandom);
    endtask

    task automatic frame_item(input logic [WORD_W-1:0] now, input logic [CMD_W-1:0] cmd,
                              input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] lo,
                              input logic [WORD_W-1:0] hi);
        offer_item(OP_FRAME, now, {node_now, cmd}, len, lo, hi);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic settle();
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Drains the block, then rewrites every register.
    task automatic load_config(input logic [NODE_W-1:0] node,
                               input logic [PERIOD_W-1:0] cmd_period,
                               input logic [PERIOD_W-1:0] retry,
                               input logic [PERIOD_W-1:0] timeout,
                               input logic [WORD_W-1:0] velocity, input logic enabled,
                               input logic [WORD_W-1:0] torque);
        @(negedge clk);
        in_valid <= 1'b0;
        settle();
        write_reg(REG_NODE_ADDRESS, {26'd0, node});
        write_reg(REG_COMMAND_PERIOD, {16'd0, cmd_period});
        write_reg(REG_ENABLE_RETRY, {16'd0, retry});
        write_reg(REG_HB_TIMEOUT, {16'd0, timeout});
        write_reg(REG_TARGET_VEL, velocity);
        write_reg(REG_DRIVE_ENABLED, {31'd0, enabled});
        write_reg(REG_TORQUE_FF, torque);
        @(negedge clk);
        cfg_write <= 1'b0;
        node_now = node;
    endtask

    // Mostly well-formed traffic for this node, with some foreign frames and noise.
    task automatic random_item();
        int                pick;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] err;
        logic [WORD_W-1:0] hi_word;
        logic [NODE_W-1:0] other;
        logic [CMD_W-1:0]  cmd;
        pick = $urandom_range(99);
        if ($urandom_range(32) == 0)
            clock_ms += $urandom;
        else if ($urandom_range(4) != 0)
            clock_ms += $urandom_range(1, 25);

        if (pick < 35)
        begin
            tick_item(clock_ms);
        end
        else if (pick < 55)
        begin
            if ($urandom_range(9) == 0)
                len = LEN_W'($urandom_range(0, 5));
            else
                len = LEN_W'($urandom_range(6, 15));
            err = ($urandom_range(7) == 0) ? $urandom : 32'd0;
            hi_word = $urandom;
            if ($urandom_range(1) == 0)
                hi_word[STATE_W-1:0] = STATE_CLOSED_LOOP;
            frame_item(clock_ms, CMD_HEARTBEAT, len, err, hi_word);
        end
        else if (pick < 75)
        begin
            len = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(0, 15)) : LEN_FULL;
            cmd = (pick < 65) ? CMD_ENCODER : CMD_IQ;
            frame_item(clock_ms, cmd, len, $urandom, $urandom);
        end
        else if (pick < 85)
        begin
            other = NODE_W'($urandom_range(1, 63));
            other = other ^ node_now;
            case ($urandom_range(2))
                0:       cmd = CMD_HEARTBEAT;
                1:       cmd = CMD_ENCODER;
                default: cmd = CMD_IQ;
            endcase
            offer_item(OP_FRAME, clock_ms, {other, cmd}, LEN_FULL, $urandom, $urandom);
        end
        else
        begin
            offer_item(OP_FRAME, clock_ms, ID_W'($urandom), LEN_W'($urandom), $urandom,
                       $urandom);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_FRAME;
        now_ms       = '0;
        rx_id        = '0;
        rx_length    = '0;
        rx_low_word  = '0;
        rx_high_word = '0;
        node_now     = RST_NODE_ADDRESS;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings.
        tick_item(32'd0);
        frame_item(32'd0, CMD_HEARTBEAT, LEN_FULL, 32'd0, 32'd1);
        tick_item(32'd5);
        frame_item(32'd100, CMD_HEARTBEAT, 4'd5, 32'd0, 32'd1);
        frame_item(32'd1050, CMD_HEARTBEAT, 4'd15, 32'd0, 32'd1);
        tick_item(32'd1100);
        tick_item(32'd1150);
        frame_item(32'd1200, CMD_HEARTBEAT, LEN_HEARTBEAT, 32'd0, 32'hFFFF_FF08);
        tick_item(32'd1250);
        tick_item(32'd1300);
        tick_item(32'd1350);
        frame_item(32'd1360, CMD_ENCODER, LEN_FULL, 32'hFFFF_FFFF, 32'd0);
        frame_item(32'd1370, CMD_ENCODER, 4'd7, 32'h1234_5678, 32'h9ABC_DEF0);
        frame_item(32'd1380, CMD_IQ, LEN_FULL, 32'd0, 32'hAAAA_5555);
        frame_item(32'd1390, CMD_IQ, 4'd9, 32'd0, 32'h5555_AAAA);
        offer_item(OP_FRAME, 32'd1395, {6'h3F, CMD_HEARTBEAT}, LEN_FULL, 32'hFFFF_FFFF, 32'd0);
        frame_item(32'd1398, CMD_UNUSED, LEN_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        frame_item(32'd1400, CMD_HEARTBEAT, LEN_FULL, 32'hFFFF_FFFF, 32'd8);
        tick_item(32'd1500);
        frame_item(32'd1600, CMD_HEARTBEAT, LEN_FULL, 32'd0, 32'h0000_00FF);
        // Heartbeat age right at the timeout and retry right at its period.
        tick_item(32'd2100);

        // Top node address, zero periods and timeout, wrap of the millisecond time.
        load_config(6'h3F, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        frame_item(32'hFFFF_FFF0, CMD_HEARTBEAT, LEN_FULL, 32'd0, 32'd8);
        tick_item(32'hFFFF_FFF0);
        tick_item(32'hFFFF_FFF0);
        tick_item(32'hFFFF_FFF1);
        load_config(6'h3F, 16'hFFFF, 16'd1, 16'hFFFF, 32'h7F7F_FFFF, 1'b1, 32'd0);
        tick_item(32'h0000_0010);
        frame_item(32'h0000_0020, CMD_HEARTBEAT, LEN_FULL, 32'd0, 32'd0);
        tick_item(32'h0000_0030);

        // Random phases, each with its own settings and idling pattern.
        for (phase = 0; phase < 8; phase++)
        begin
            load_config((phase == 0) ? 6'h3F : (phase == 1) ? 6'h00 : 6'($urandom_range(63)),
                        (phase == 5) ? 16'hFFFF : (phase == 6) ? 16'd1
                                     : 16'($urandom_range(0, 40)),
                        (phase == 5) ? 16'hFFFF : (phase == 6) ? 16'd1
                                     : 16'($urandom_range(10, 150)),
                        (phase == 5) ? 16'hFFFF : (phase == 6) ? 16'd0
                                     : 16'($urandom_range(40, 300)),
                        $urandom, 1'($urandom_range(1)), $urandom);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 87;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 87;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    stall_pct       = 33;
                end
            endcase
            clock_ms = $urandom;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold the receiver off while items keep coming, to fill the block.
                if (phase == 0 && n == 10)
                    hold_requests++;
                random_item();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/cmds_pkg.sv
rtl/core/cmds_config.sv
rtl/core/cmds_core.sv
rtl/core/cmds_out.sv
rtl/core/can_motor_drive_supervisor_unit.sv
tb/supervisor_checker.sv
tb/testbench.sv
